### hdl/spq_pkg.sv
// Shared types, codes and sizes for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int ID_BITS  = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;
  localparam logic [1:0] CMD_CHANGE  = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [15:0]        order;
    logic signed [31:0] prio;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } cell_op_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    cell_op_t           op;
    logic [ID_BITS-1:0] key;
    entry_t             ins;
  } cell_ctl_t;

  // Travels from a cell to its right neighbor.
  typedef struct packed {
    entry_t e;
    logic   valid;
    logic   keeps;
    logic   hit;
    entry_t carry;
  } link_fwd_t;

  // Travels from a cell to its left neighbor.
  typedef struct packed {
    entry_t e;
    logic   valid;
  } link_bwd_t;

  typedef enum logic {
    S_IDLE,
    S_REINSERT
  } state_t;

endpackage

### hdl/sorted_priority_queue_core.sv
// Sorted minimum priority queue built as a row of shifting cells.
// Insert, extract and remove: done pulses in the cycle after start is taken, busy stays low.
// Change priority: a remove pass, then a re-insert pass; if the id is found, busy is high
// for one cycle and done pulses after the re-insert pass. The compare and first-match
// chain through the cell row sets the clock period. Reset (rst, synchronous) empties the
// queue and clears busy and done; the receiver cannot stall, each result is shown for one cycle.
module sorted_priority_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  cmd,
  input  logic [15:0] item_id,
  input  logic [15:0] item_order,
  input  logic signed [31:0] item_priority,
  output logic        busy,
  output logic        done,
  output logic [15:0] out_id,
  output logic [15:0] out_order,
  output logic signed [31:0] out_priority,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);
  import spq_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] held_count_next;
  entry_t     held;
  cell_ctl_t  ctl;
  logic       force_head;
  logic       accept;
  logic       found;
  logic       empty;
  logic       full;
  logic       res_fire;
  logic       res_take;
  logic [1:0] res_stat;
  logic [CAPACITY-1:0] valid_vec;

  link_fwd_t fwd [CAPACITY+1];
  link_bwd_t bwd [CAPACITY+1];

  assign fwd[0].e = '0;
  assign fwd[0].valid = 1'b1;
  assign fwd[0].keeps = 1'b1;
  assign fwd[0].hit = force_head;
  assign fwd[0].carry = '0;
  assign bwd[CAPACITY].e = '0;
  assign bwd[CAPACITY].valid = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .from_left  (fwd[i]),
      .from_right (bwd[i+1]),
      .to_right   (fwd[i+1]),
      .to_left    (bwd[i])
    );
    assign valid_vec[i] = bwd[i].valid;
  end

  assign busy   = (state == S_REINSERT);
  assign accept = start && !busy;
  assign found  = fwd[CAPACITY].hit;
  assign empty  = (held_count == '0);
  assign full   = (held_count == CNT_W'(CAPACITY));
  assign entry_count = 5'(held_count);

  always_comb begin
    state_next = state;
    held_count_next = held_count;
    ctl.op = OP_HOLD;
    ctl.key = ID_BITS'(item_id);
    ctl.ins.id = ID_BITS'(item_id);
    ctl.ins.order = item_order;
    ctl.ins.prio = item_priority;
    force_head = 1'b0;
    res_fire = 1'b0;
    res_take = 1'b0;
    res_stat = STAT_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd) inside
            CMD_INSERT: begin
              res_fire = 1'b1;
              if (full) begin
                res_stat = STAT_FULL;
              end else begin
                ctl.op = OP_INSERT;
                held_count_next = held_count + 1'b1;
              end
            end
            CMD_EXTRACT: begin
              res_fire = 1'b1;
              if (empty) begin
                res_stat = STAT_EMPTY;
              end else begin
                ctl.op = OP_REMOVE;
                force_head = 1'b1;
                res_take = 1'b1;
                held_count_next = held_count - 1'b1;
              end
            end
            CMD_REMOVE, CMD_CHANGE: begin
              // With no match no cell shifts, so the remove pass is harmless.
              ctl.op = OP_REMOVE;
              if (empty) begin
                res_fire = 1'b1;
                res_stat = STAT_EMPTY;
              end else if (!found) begin
                res_fire = 1'b1;
                res_stat = STAT_NOT_FOUND;
              end else begin
                held_count_next = held_count - 1'b1;
                if (cmd == CMD_REMOVE) begin
                  res_fire = 1'b1;
                end else begin
                  state_next = S_REINSERT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_REINSERT: begin
        ctl.op = OP_INSERT;
        ctl.ins = held;
        res_fire = 1'b1;
        held_count_next = held_count + 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held_count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      held_count <= held_count_next;
      done <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      held.id <= fwd[CAPACITY].carry.id;
      held.order <= fwd[CAPACITY].carry.order;
      held.prio <= item_priority;
    end
    if (res_fire) begin
      out_id <= res_take ? 16'(bwd[0].e.id) : '0;
      out_order <= res_take ? bwd[0].e.order : '0;
      out_priority <= res_take ? bwd[0].e.prio : '0;
      status <= res_stat;
    end
  end

  a_busy_from_change: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && cmd == CMD_CHANGE))
    else $error("busy rose without a change-priority beat");

  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == held_count)
    else $error("occupied cells disagree with the entry count");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && status == STAT_FULL |-> held_count == CNT_W'(CAPACITY))
    else $error("full status reported while the queue has room");

  a_reinsert_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("re-insert pass did not produce a result");

endmodule

### hdl/spq_cell.sv
// One slot of the sorted queue: holds an entry and shifts it left or right.
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::link_fwd_t from_left,
  input  spq_pkg::link_bwd_t from_right,
  output spq_pkg::link_fwd_t to_right,
  output spq_pkg::link_bwd_t to_left
);
  import spq_pkg::*;

  entry_t e;
  entry_t e_next;
  logic   valid;
  logic   valid_next;
  logic   keeps;
  logic   match;
  logic   shift;

  always_comb begin
    keeps = valid && ($signed(e.prio) < $signed(ctl.ins.prio));
    match = valid && (e.id == ctl.key);
    // Every cell at or beyond the first match closes the gap.
    shift = from_left.hit || match;
    e_next = e;
    valid_next = valid;
    unique case (ctl.op)
      OP_INSERT: begin
        if (!keeps) begin
          if (from_left.keeps) begin
            e_next = ctl.ins;
            valid_next = 1'b1;
          end else begin
            e_next = from_left.e;
            valid_next = from_left.valid;
          end
        end
      end
      OP_REMOVE: begin
        if (shift) begin
          e_next = from_right.e;
          valid_next = from_right.valid;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    to_right.e = e;
    to_right.valid = valid;
    to_right.keeps = keeps;
    to_right.hit = shift;
    // The first matching cell hands its entry down the row.
    to_right.carry = (match && !from_left.hit) ? e : from_left.carry;
    to_left.e = e;
    to_left.valid = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    e <= e_next;
  end

endmodule
